// File: rtl/calendar_entry_date_match_top_assert.svh
// assertion macros for the calendar entry date match block
`ifndef CALENDAR_ENTRY_DATE_MATCH_TOP_ASSERT_SVH
`define CALENDAR_ENTRY_DATE_MATCH_TOP_ASSERT_SVH

// same-cycle implication, disabled while in reset
`define CEDM_ASSERT_IMPL(label, ante, cons, msg) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> cons) \
    else $error(msg);

// next-cycle implication, disabled while in reset
`define CEDM_ASSERT_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> cons) \
    else $error(msg);

`endif

// File: rtl/cedm_pkg.sv
// types, constants and helper functions for the calendar entry date match block
package cedm_pkg;

  localparam int unsigned YearW    = 8;
  localparam int unsigned MonthW   = 4;
  localparam int unsigned DayW     = 5;
  localparam int unsigned WeekdayW = 3;
  localparam int unsigned DateW    = 24;
  localparam int unsigned FieldW   = 8;
  localparam int unsigned CfgIdxW  = 3;

  localparam logic [FieldW-1:0] Wildcard    = 8'hff;
  localparam logic [FieldW-1:0] MonthOdd    = 8'd13;
  localparam logic [FieldW-1:0] MonthEven   = 8'd14;
  localparam logic [FieldW-1:0] WeekFirst   = 8'd1;
  localparam logic [FieldW-1:0] WeekLastFwd = 8'd5;
  localparam logic [FieldW-1:0] WeekFromEnd = 8'd6;
  localparam logic [FieldW-1:0] WeekLastEnd = 8'd9;

  // year offsets of the century years 1900 and 2100, which are not leap
  localparam logic [YearW-1:0] Year1900Off = 8'd0;
  localparam logic [YearW-1:0] Year2100Off = 8'd200;

  typedef enum logic [1:0] {
    KIND_SINGLE  = 2'd0,
    KIND_RANGE   = 2'd1,
    KIND_PATTERN = 2'd2,
    KIND_NONE    = 2'd3
  } entry_kind_e;

  typedef enum logic [CfgIdxW-1:0] {
    REG_ENTRY_KIND      = 3'd0,
    REG_FIRST_DATE      = 3'd1,
    REG_LAST_DATE       = 3'd2,
    REG_PATTERN_MONTH   = 3'd3,
    REG_PATTERN_WEEK    = 3'd4,
    REG_PATTERN_WEEKDAY = 3'd5
  } cfg_reg_e;

  // gregorian leap year for years 1900 to 2155 given as offsets
  function automatic logic is_leap(input logic [YearW-1:0] year_off);
    is_leap = (year_off[1:0] == 2'b00) && (year_off != Year1900Off) &&
              (year_off != Year2100Off);
  endfunction

  // month length, zero for a month outside 1 to 12
  function automatic logic [DayW-1:0] days_in_month(input logic              leap,
                                                    input logic [MonthW-1:0] month);
    logic [DayW-1:0] len;
    case (month)
      4'd1, 4'd3, 4'd5, 4'd7, 4'd8, 4'd10, 4'd12: len = 5'd31;
      4'd4, 4'd6, 4'd9, 4'd11:                   len = 5'd30;
      4'd2:                                      len = leap ? 5'd29 : 5'd28;
      default:                                   len = 5'd0;
    endcase
    days_in_month = len;
  endfunction

  // remainder by seven of a value below 32, three compare-subtract steps
  function automatic logic [2:0] mod7(input logic [DayW-1:0] x);
    logic [DayW-1:0] v;
    v = x;
    if (v >= 5'd28) v = v - 5'd28;
    if (v >= 5'd14) v = v - 5'd14;
    if (v >= 5'd7)  v = v - 5'd7;
    mod7 = v[2:0];
  endfunction

endpackage

// File: rtl/calendar_entry_date_match_top.sv
// calendar entry date match: one date compared against one configured entry
//
//   channel  | handshake             | payload
//   ---------+-----------------------+-------------------------------------------
//   request  | start_i / busy_o      | date_year_i, date_month_i, date_day_i,
//            |                       | date_weekday_i
//   result   | done_o (one cycle)    | matches_res_o
//   config   | cfg_we_i              | cfg_idx_i, cfg_data_i
//
// a request is taken at every edge where start_i is high; busy_o stays low
// each request passes through one input register, then the compare logic and
// one result register
// requests may follow each other in every cycle, one result per cycle
// reset clears the entry registers to their defaults and drops any request in flight
// the receiver cannot stall, so nothing is ever held back
module calendar_entry_date_match_top
  import cedm_pkg::*;
(
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                start_i,
  output logic                busy_o,
  input  logic [YearW-1:0]    date_year_i,
  input  logic [MonthW-1:0]   date_month_i,
  input  logic [DayW-1:0]     date_day_i,
  input  logic [WeekdayW-1:0] date_weekday_i,
  output logic                done_o,
  output logic                matches_res_o,
  input  logic                cfg_we_i,
  input  logic [CfgIdxW-1:0]  cfg_idx_i,
  input  logic [DateW-1:0]    cfg_data_i
);

  // entry registers
  entry_kind_e       entry_kind_q;
  logic [DateW-1:0]  first_date_q;
  logic [DateW-1:0]  last_date_q;
  logic [FieldW-1:0] pattern_month_q;
  logic [FieldW-1:0] pattern_week_q;
  logic [FieldW-1:0] pattern_weekday_q;

  // input stage
  logic                in_vld_q;
  logic [YearW-1:0]    year_q;
  logic [MonthW-1:0]   month_q;
  logic [DayW-1:0]     day_q;
  logic [WeekdayW-1:0] weekday_q;

  // result stage
  logic done_q;
  logic match_q;
  logic match_d;

  // compare logic
  logic [DateW-1:0] packed_date;
  logic             month_ok;
  logic             week_ok;
  logic             weekday_ok;
  logic [DayW-1:0]  month_len;
  logic [DayW-1:0]  day_m1;
  logic [DayW-1:0]  days_left;
  logic [2:0]       week_fwd;
  logic [2:0]       week_end;

  // never stalls: the pipeline takes a request every cycle
  assign busy_o = 1'b0;

  // configuration writes; indexes past the list are ignored
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      entry_kind_q      <= KIND_NONE;
      first_date_q      <= '0;
      last_date_q       <= '0;
      pattern_month_q   <= Wildcard;
      pattern_week_q    <= Wildcard;
      pattern_weekday_q <= Wildcard;
    end else if (cfg_we_i) begin
      unique case (cfg_idx_i)
        REG_ENTRY_KIND:      entry_kind_q      <= entry_kind_e'(cfg_data_i[1:0]);
        REG_FIRST_DATE:      first_date_q      <= cfg_data_i;
        REG_LAST_DATE:       last_date_q       <= cfg_data_i;
        REG_PATTERN_MONTH:   pattern_month_q   <= cfg_data_i[FieldW-1:0];
        REG_PATTERN_WEEK:    pattern_week_q    <= cfg_data_i[FieldW-1:0];
        REG_PATTERN_WEEKDAY: pattern_weekday_q <= cfg_data_i[FieldW-1:0];
        default: ;
      endcase
    end
  end

  // input register: valid is cleared by reset, payload is not
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_vld_q <= 1'b0;
    end else begin
      in_vld_q <= start_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (start_i) begin
      year_q    <= date_year_i;
      month_q   <= date_month_i;
      day_q     <= date_day_i;
      weekday_q <= date_weekday_i;
    end
  end

  // packed the same way as the date registers so one ordered compare does
  assign packed_date = {year_q, 4'b0000, month_q, 3'b000, day_q};

  // month rule, date month zero counts as even
  assign month_ok = (pattern_month_q == Wildcard) ||
                    (pattern_month_q == {4'b0000, month_q}) ||
                    ((pattern_month_q == MonthOdd) && month_q[0]) ||
                    ((pattern_month_q == MonthEven) && !month_q[0]);

  // week rule: seven-day blocks from day one or counted back from the month end
  assign month_len = days_in_month(is_leap(year_q), month_q);
  assign day_m1    = day_q - 5'd1;
  assign days_left = month_len - day_q;
  assign week_fwd  = mod7(day_m1);
  assign week_end  = mod7(days_left);

  always_comb begin
    week_ok = 1'b0;
    if (pattern_week_q == Wildcard) begin
      week_ok = 1'b1;
    end else if ((pattern_week_q >= WeekFirst) && (pattern_week_q <= WeekLastFwd)) begin
      // day zero never matches
      week_ok = (day_q != '0) && (pattern_week_q == {5'b00000, week_fwd} + 8'd1);
    end else if ((pattern_week_q >= WeekFromEnd) && (pattern_week_q <= WeekLastEnd)) begin
      // unknown month or a day past the month end never matches
      week_ok = (month_len != '0) && (day_q <= month_len) &&
                ((pattern_week_q - WeekFromEnd) == {5'b00000, week_end});
    end
  end

  assign weekday_ok = (pattern_weekday_q == Wildcard) ||
                      (pattern_weekday_q == {5'b00000, weekday_q});

  always_comb begin
    case (entry_kind_q)
      KIND_SINGLE:  match_d = (packed_date == first_date_q);
      KIND_RANGE:   match_d = (first_date_q <= packed_date) && (packed_date <= last_date_q);
      KIND_PATTERN: match_d = month_ok && week_ok && weekday_ok;
      default:      match_d = 1'b0;
    endcase
  end

  // result register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      done_q <= 1'b0;
    end else begin
      done_q <= in_vld_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_vld_q) begin
      match_q <= match_d;
    end
  end

  assign done_o        = done_q;
  assign matches_res_o = match_q;

endmodule

// File: rtl/cedm_checker.sv
// port-level checks for the calendar entry date match block, with its bind
`include "calendar_entry_date_match_top_assert.svh"

module cedm_checker
  import cedm_pkg::*;
(
  input logic clk_i,
  input logic rst_ni,
  input logic start_i,
  input logic busy_o,
  input logic done_o
);

  // every request is answered with a result strobe
  `CEDM_ASSERT_NEXT(a_req_gives_result, start_i && !busy_o, ##1 done_o, "request lost")

  // no result without an earlier request
  `CEDM_ASSERT_IMPL(a_result_has_req, done_o, $past(start_i && !busy_o, 2), "result invented")

  // nothing comes out straight after reset
  `CEDM_ASSERT_IMPL(a_quiet_after_reset, $rose(rst_ni), !done_o, "result after reset")

  // the block takes a request in every cycle
  `CEDM_ASSERT_IMPL(a_never_busy, start_i, !busy_o, "request refused")

endmodule

bind calendar_entry_date_match_top cedm_checker u_cedm_checker (.*);

// File: tb/calendar_entry_date_match_top_tb.sv
// self-checking testbench for the calendar entry date match block
`timescale 1ns / 1ps
module calendar_entry_date_match_top_tb;
  import cedm_pkg::*;

  // selector values of the week-and-day entry
  localparam logic [FieldW-1:0] AnyValue   = 8'hff;
  localparam logic [FieldW-1:0] OddMonths  = 8'd13;
  localparam logic [FieldW-1:0] EvenMonths = 8'd14;
  localparam int unsigned FwdBlockLast  = 5;
  localparam int unsigned EndBlockFirst = 6;
  localparam int unsigned EndBlockLast  = 9;
  localparam int unsigned DaysPerWeek   = 7;
  // register indexes past the end of the list, writes there must change nothing
  localparam logic [CfgIdxW-1:0] RegSpareLo = 3'd6;
  localparam logic [CfgIdxW-1:0] RegSpareHi = 3'd7;
  // margin waited out after the last result, before any register write
  localparam int unsigned SettleCycles = 4;

  typedef struct packed {
    logic [DateW-1:0]    key;
    logic [WeekdayW-1:0] wday;
    logic                hit;
  } verdict_t;

  logic                clk_i          = 1'b0;
  logic                rst_ni         = 1'b0;
  logic                start_i        = 1'b0;
  logic                busy_o;
  logic [YearW-1:0]    date_year_i    = '0;
  logic [MonthW-1:0]   date_month_i   = '0;
  logic [DayW-1:0]     date_day_i     = '0;
  logic [WeekdayW-1:0] date_weekday_i = '0;
  logic                done_o;
  logic                matches_res_o;
  logic                cfg_we_i       = 1'b0;
  logic [CfgIdxW-1:0]  cfg_idx_i      = '0;
  logic [DateW-1:0]    cfg_data_i     = '0;

  // shadow copy of the entry registers, at their reset values
  entry_kind_e       shadow_kind  = KIND_NONE;
  logic [DateW-1:0]  shadow_first = '0;
  logic [DateW-1:0]  shadow_last  = '0;
  logic [FieldW-1:0] shadow_month = AnyValue;
  logic [FieldW-1:0] shadow_week  = AnyValue;
  logic [FieldW-1:0] shadow_wday  = AnyValue;

  verdict_t pending_verdicts[$];
  int       mismatches = 0;
  // chance in percent that a request is preceded by an idle burst
  int       idle_pct   = 0;

  calendar_entry_date_match_top dut (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .start_i        (start_i),
    .busy_o         (busy_o),
    .date_year_i    (date_year_i),
    .date_month_i   (date_month_i),
    .date_day_i     (date_day_i),
    .date_weekday_i (date_weekday_i),
    .done_o         (done_o),
    .matches_res_o  (matches_res_o),
    .cfg_we_i       (cfg_we_i),
    .cfg_idx_i      (cfg_idx_i),
    .cfg_data_i     (cfg_data_i)
  );

  always begin
    #5 clk_i = 1'b1;
    #5 clk_i = 1'b0;
  end

  // same packing as the date registers: year, month and day in their own bytes
  function automatic logic [DateW-1:0] date_key(input logic [YearW-1:0]  yr,
                                                input logic [MonthW-1:0] mon,
                                                input logic [DayW-1:0]   dy);
    return {yr, 4'd0, mon, 3'd0, dy};
  endfunction

  // does the configured entry include this date
  function automatic logic entry_includes(input logic [YearW-1:0]    yr,
                                          input logic [MonthW-1:0]   mon,
                                          input logic [DayW-1:0]     dy,
                                          input logic [WeekdayW-1:0] wday);
    int unsigned full_year;
    int unsigned month_len;
    int unsigned wk;
    int unsigned day_n;
    logic        leap;
    logic        month_hit;
    logic        week_hit;
    logic        wday_hit;
    logic [DateW-1:0] key;
    key       = date_key(yr, mon, dy);
    full_year = 1900 + int'(yr);
    day_n     = int'(dy);
    leap      = (full_year % 4 == 0) && ((full_year % 100 != 0) || (full_year % 400 == 0));
    case (mon)
      4'd1, 4'd3, 4'd5, 4'd7, 4'd8, 4'd10, 4'd12: month_len = 31;
      4'd4, 4'd6, 4'd9, 4'd11:                    month_len = 30;
      4'd2:                                       month_len = leap ? 29 : 28;
      default:                                    month_len = 0;
    endcase
    // month zero counts as even
    month_hit = (shadow_month == AnyValue) || (shadow_month == {4'd0, mon}) ||
                ((shadow_month == OddMonths) && mon[0]) ||
                ((shadow_month == EvenMonths) && !mon[0]);
    wk = int'(shadow_week);
    if (shadow_week == AnyValue) begin
      week_hit = 1'b1;
    end else if (wk >= 1 && wk <= FwdBlockLast) begin
      // seven-day blocks counted from the first of the month
      week_hit = (day_n != 0) && (wk == (day_n - 1) % DaysPerWeek + 1);
    end else if (wk >= EndBlockFirst && wk <= EndBlockLast) begin
      // seven-day blocks counted back from the last day of the month
      week_hit = (month_len != 0) && (day_n <= month_len) &&
                 (wk - EndBlockFirst == (month_len - day_n) % DaysPerWeek);
    end else begin
      week_hit = 1'b0;
    end
    wday_hit = (shadow_wday == AnyValue) || (shadow_wday == {5'd0, wday});
    case (shadow_kind)
      KIND_SINGLE:  return key == shadow_first;
      KIND_RANGE:   return (shadow_first <= key) && (key <= shadow_last);
      KIND_PATTERN: return month_hit && week_hit && wday_hit;
      default:      return 1'b0;
    endcase
  endfunction

  // mostly real calendar fields, now and then raw bits
  function automatic logic [DateW-1:0] random_date();
    logic [31:0] r;
    logic [31:0] m;
    logic [31:0] d;
    r = $urandom;
    if ($urandom_range(15) == 0) begin
      m = $urandom;
      d = $urandom;
    end else begin
      m = $urandom_range(12, 1);
      d = $urandom_range(31, 1);
    end
    return date_key(r[YearW-1:0], m[MonthW-1:0], d[DayW-1:0]);
  endfunction

  function automatic logic [WeekdayW-1:0] random_weekday();
    logic [31:0] r;
    r = ($urandom_range(15) == 0) ? $urandom : $urandom_range(7, 1);
    return r[WeekdayW-1:0];
  endfunction

  // wildcard, a meaningful value or any byte at all
  function automatic logic [FieldW-1:0] random_selector(input int unsigned lo_v,
                                                        input int unsigned hi_v);
    logic [31:0] r;
    case ($urandom_range(9))
      0, 1, 2: r = 32'(AnyValue);
      3:       r = $urandom;
      default: r = $urandom_range(hi_v, lo_v);
    endcase
    return r[FieldW-1:0];
  endfunction

  // stop sending and wait until every outstanding result is back
  task automatic settle();
    start_i <= 1'b0;
    while (pending_verdicts.size() != 0) @(posedge clk_i);
    repeat (SettleCycles) @(posedge clk_i);
  endtask

  // one register write; leaves the write enable high for a following write
  task automatic write_reg(input logic [CfgIdxW-1:0] idx, input logic [DateW-1:0] data);
    cfg_we_i   <= 1'b1;
    cfg_idx_i  <= idx;
    cfg_data_i <= data;
    @(posedge clk_i);
    case (idx)
      REG_ENTRY_KIND:      shadow_kind  = entry_kind_e'(data[1:0]);
      REG_FIRST_DATE:      shadow_first = data;
      REG_LAST_DATE:       shadow_last  = data;
      REG_PATTERN_MONTH:   shadow_month = data[FieldW-1:0];
      REG_PATTERN_WEEK:    shadow_week  = data[FieldW-1:0];
      REG_PATTERN_WEEKDAY: shadow_wday  = data[FieldW-1:0];
      default: ;
    endcase
  endtask

  // rewrite the whole entry while idle; unused upper data bits carry noise
  task automatic set_entry(input entry_kind_e       kind,
                           input logic [DateW-1:0]  first_key,
                           input logic [DateW-1:0]  last_key,
                           input logic [FieldW-1:0] month_sel,
                           input logic [FieldW-1:0] week_sel,
                           input logic [FieldW-1:0] wday_sel,
                           input bit                poke_spare);
    logic [31:0] noise;
    settle();
    noise = $urandom;
    write_reg(REG_ENTRY_KIND, {noise[DateW-1:2], kind});
    write_reg(REG_FIRST_DATE, first_key);
    write_reg(REG_LAST_DATE, last_key);
    noise = $urandom;
    write_reg(REG_PATTERN_MONTH, {noise[DateW-1:FieldW], month_sel});
    noise = $urandom;
    write_reg(REG_PATTERN_WEEK, {noise[DateW-1:FieldW], week_sel});
    noise = $urandom;
    write_reg(REG_PATTERN_WEEKDAY, {noise[DateW-1:FieldW], wday_sel});
    if (poke_spare) begin
      write_reg(RegSpareLo, '0);
      write_reg(RegSpareHi, '1);
    end
    cfg_we_i <= 1'b0;
  endtask

  // present one request, wait for it to be taken and note its expected result
  task automatic send_date(input logic [DateW-1:0] key, input logic [WeekdayW-1:0] wday);
    verdict_t v;
    if (idle_pct != 0 && $urandom_range(99) < idle_pct) begin
      start_i <= 1'b0;
      repeat ($urandom_range(5, 1)) @(posedge clk_i);
    end
    start_i        <= 1'b1;
    date_year_i    <= key[23:16];
    date_month_i   <= key[11:8];
    date_day_i     <= key[4:0];
    date_weekday_i <= wday;
    do begin
      @(posedge clk_i);
    end while (busy_o);
    v.key  = date_key(key[23:16], key[11:8], key[4:0]);
    v.wday = wday;
    v.hit  = entry_includes(key[23:16], key[11:8], key[4:0], wday);
    pending_verdicts.push_back(v);
  endtask

  // result checker: every strobe must pair with the oldest outstanding request
  always @(posedge clk_i) begin
    verdict_t want;
    if (rst_ni && done_o !== 1'b0) begin
      if (pending_verdicts.size() == 0) begin
        $display("%0t: unexpected result, expected none, actual matches_res %b",
                 $time, matches_res_o);
        mismatches++;
      end else begin
        want = pending_verdicts.pop_front();
        if (done_o !== 1'b1 || matches_res_o !== want.hit) begin
          $display("%0t: date %h weekday %0d: matches_res expected %b, actual %b (done %b)",
                   $time, want.key, want.wday, want.hit, matches_res_o, done_o);
          mismatches++;
        end
      end
    end
  end

  // entry registers straight out of reset: kind none, so nothing matches
  task automatic test_reset_defaults();
    send_date(date_key(8'd0, 4'd1, 5'd1), 3'd1);
  endtask

  task automatic test_single_date();
    set_entry(KIND_SINGLE, date_key(8'd124, 4'd2, 5'd29), '0,
              AnyValue, AnyValue, AnyValue, 1'b0);
    send_date(date_key(8'd124, 4'd2, 5'd29), 3'd4);
    send_date(date_key(8'd124, 4'd2, 5'd28), 3'd3);
    // field extremes on both sides
    set_entry(KIND_SINGLE, date_key(8'd255, 4'd12, 5'd31), '0,
              AnyValue, AnyValue, AnyValue, 1'b0);
    send_date(date_key(8'd255, 4'd12, 5'd31), 3'd7);
    send_date(date_key(8'd0, 4'd1, 5'd1), 3'd1);
  endtask

  task automatic test_date_range();
    set_entry(KIND_RANGE, date_key(8'd100, 4'd6, 5'd15), date_key(8'd101, 4'd1, 5'd1),
              AnyValue, AnyValue, AnyValue, 1'b0);
    // both ends are inclusive
    send_date(date_key(8'd100, 4'd6, 5'd15), 3'd2);
    send_date(date_key(8'd101, 4'd1, 5'd1), 3'd5);
    send_date(date_key(8'd100, 4'd6, 5'd14), 3'd1);
    send_date(date_key(8'd101, 4'd1, 5'd2), 3'd6);
    send_date(date_key(8'd100, 4'd12, 5'd31), 3'd7);
    // widest range takes even an impossible month
    set_entry(KIND_RANGE, '0, '1, AnyValue, AnyValue, AnyValue, 1'b0);
    send_date(date_key(8'd255, 4'd15, 5'd31), 3'd0);
    // reversed ends take nothing
    set_entry(KIND_RANGE, date_key(8'd101, 4'd1, 5'd1), date_key(8'd100, 4'd6, 5'd15),
              AnyValue, AnyValue, AnyValue, 1'b0);
    send_date(date_key(8'd100, 4'd9, 5'd9), 3'd3);
  endtask

  task automatic test_week_pattern();
    set_entry(KIND_PATTERN, '0, '0, OddMonths, AnyValue, AnyValue, 1'b0);
    send_date(date_key(8'd50, 4'd7, 5'd10), 3'd2);
    send_date(date_key(8'd50, 4'd8, 5'd10), 3'd2);
    // month zero falls under even months
    set_entry(KIND_PATTERN, '0, '0, EvenMonths, AnyValue, AnyValue, 1'b0);
    send_date(date_key(8'd50, 4'd0, 5'd10), 3'd2);
    // first block from day one; day zero is never in a block
    set_entry(KIND_PATTERN, '0, '0, AnyValue, 8'd1, AnyValue, 1'b0);
    send_date(date_key(8'd50, 4'd3, 5'd29), 3'd1);
    send_date(date_key(8'd50, 4'd3, 5'd0), 3'd1);
    // last block of february across leap rules: 2000 leap, 1900 and 2100 not
    set_entry(KIND_PATTERN, '0, '0, AnyValue, 8'd6, AnyValue, 1'b0);
    send_date(date_key(8'd100, 4'd2, 5'd29), 3'd2);
    send_date(date_key(8'd200, 4'd2, 5'd28), 3'd7);
    send_date(date_key(8'd200, 4'd2, 5'd29), 3'd1);
    send_date(date_key(8'd0, 4'd2, 5'd28), 3'd3);
    // fourth block from the end with a weekday; an impossible month never matches
    set_entry(KIND_PATTERN, '0, '0, AnyValue, 8'd9, 8'd3, 1'b0);
    send_date(date_key(8'd60, 4'd3, 5'd28), 3'd3);
    send_date(date_key(8'd60, 4'd3, 5'd28), 3'd4);
    send_date(date_key(8'd60, 4'd13, 5'd1), 3'd3);
    // week value outside both block ranges
    set_entry(KIND_PATTERN, '0, '0, AnyValue, 8'd10, AnyValue, 1'b0);
    send_date(date_key(8'd60, 4'd3, 5'd28), 3'd3);
  endtask

  // writes past the register list must leave an all-wildcard pattern intact
  task automatic test_no_entry();
    set_entry(KIND_PATTERN, '0, '0, AnyValue, AnyValue, AnyValue, 1'b1);
    send_date(date_key(8'd77, 4'd5, 5'd17), 3'd0);
    set_entry(KIND_NONE, '0, '0, AnyValue, AnyValue, AnyValue, 1'b0);
    send_date(date_key(8'd77, 4'd5, 5'd17), 3'd5);
  endtask

  // random entries, each followed by requests aimed at its edges
  task automatic test_random_entries(input int phases, input int per_phase,
                                     input bit with_gaps);
    logic [31:0]       r;
    entry_kind_e       kind;
    logic [DateW-1:0]  lo;
    logic [DateW-1:0]  hi;
    logic [DateW-1:0]  key;
    logic [DateW-1:0]  swap;
    for (int p = 0; p < phases; p++) begin
      r    = $urandom;
      kind = entry_kind_e'(r[1:0]);
      lo   = random_date();
      hi   = random_date();
      // keep most ranges within a few years so that hits are common
      r = $urandom_range(2);
      hi[23:16] = lo[23:16] + r[7:0];
      if (hi < lo && $urandom_range(7) != 0) begin
        swap = lo;
        lo   = hi;
        hi   = swap;
      end
      if ($urandom_range(7) == 0) lo = '0;
      if ($urandom_range(7) == 0) hi = '1;
      set_entry(kind, lo, hi, random_selector(1, 14), random_selector(1, EndBlockLast),
                random_selector(1, 7), 1'b0);
      case ($urandom_range(2))
        0:       idle_pct = 0;
        1:       idle_pct = 15;
        default: idle_pct = 40;
      endcase
      if (!with_gaps) idle_pct = 0;
      for (int i = 0; i < per_phase; i++) begin
        key = random_date();
        case ($urandom_range(11))
          0: key = lo;
          1: key = hi;
          2: key = lo - 24'd1;
          3: key = hi + 24'd1;
          4, 5, 6, 7: begin
            r = $urandom_range(2);
            key[23:16] = lo[23:16] + r[7:0];
          end
          default: ;
        endcase
        send_date(key, random_weekday());
      end
    end
  endtask

  initial begin
    repeat (2) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    idle_pct = 20;
    test_reset_defaults();
    test_single_date();
    test_date_range();
    test_week_pattern();
    test_no_entry();

    // bulk of the run with idle bursts, then a back-to-back tail
    test_random_entries(28, 60, 1'b1);
    test_random_entries(5, 55, 1'b0);

    settle();
    if (mismatches == 0) begin
      $display("calendar_entry_date_match_top_tb passed");
    end else begin
      $display("calendar_entry_date_match_top_tb failed");
    end
    $finish;
  end

  // watchdog, far beyond the slowest correct run
  initial begin
    #2000000;
    $display("calendar_entry_date_match_top_tb failed");
    $finish;
  end

endmodule
